@@ hdl/min_max_rescale_defines.svh @@
// Assertion macros shared by the min_max_rescale RTL.
`ifndef MIN_MAX_RESCALE_DEFINES_SVH
`define MIN_MAX_RESCALE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MMR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min_max_rescale: assertion failed");

// next-cycle implication
`define MMR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min_max_rescale: assertion failed");

`else

`define MMR_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define MMR_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/mmr_pkg.sv @@
package mmr_pkg;

    localparam int DATA_W      = 32;   // Q16.16 field width
    localparam int MIN_W       = 33;   // running min/max, signed
    localparam int RANGE_W     = 34;   // max - min, unsigned
    localparam int TRANGE_W    = 31;
    localparam int FRAC_W      = 16;
    localparam int NUM_W       = TRANGE_W + FRAC_W;   // divider numerator
    localparam int SCALE_W     = 48;
    localparam int SCALE_SPLIT = 24;
    localparam int OFF_W       = 33;
    localparam int PROD_W      = OFF_W + SCALE_SPLIT;
    localparam int FULL_W      = PROD_W + SCALE_SPLIT;   // full offset x scale
    localparam int CAP_BIT     = 62;                     // products capped at 2^62
    localparam int STR_W       = CAP_BIT - FRAC_W + 1;   // stretched offset
    localparam int SUM_W       = 50;
    localparam int VALUE_WIDTH = 32;   // saturation width
    localparam int BLOCK_DEPTH_DEF = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_SPAN    = 3'd4;

    localparam logic [SCALE_W-1:0]  SCALE_ONE       = 48'd65536;
    localparam logic [TRANGE_W-1:0] TRANGE_RESET    = 31'd65536;
    localparam logic signed [MIN_W-1:0] MIN_RESET   = 33'sh0_FFFF_FFFF;
    localparam logic signed [MIN_W-1:0] MAX_RESET   = 33'sh1_0000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic signed [DATA_W-1:0] span_length;
        logic                     block_end;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] scaled_value;
        logic signed [DATA_W-1:0] found_minimum;
        logic [DATA_W-1:0]        found_range;
        logic                     run_end;
    } t_out_item;

    // marks an item moving down the emit pipeline
    typedef struct packed {
        logic vld;
        logic last;
    } t_tag;

    // per-block settings seen by the rescale pipeline
    typedef struct packed {
        logic signed [MIN_W-1:0] minimum;
        logic [SCALE_W-1:0]      scale;
        logic signed [MIN_W-1:0] base;
        logic                    stretch;
    } t_scale_cfg;

    // clamp to signed VALUE_WIDTH, keep the low 32 bits
    function automatic logic [DATA_W-1:0] sat_value(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic [DATA_W-1:0]       r;
        hi = SUM_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
        lo = ~hi;
        if (v > hi) begin
            r = hi[DATA_W-1:0];
        end else if (v < lo) begin
            r = lo[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/mmr_store.sv @@
module mmr_store #(
    parameter int DEPTH = mmr_pkg::BLOCK_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [mmr_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [mmr_pkg::DATA_W-1:0] o_rdata
);

    logic [mmr_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [mmr_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/mmr_div.sv @@
`include "min_max_rescale_defines.svh"

// Restoring divider, one quotient bit per cycle.
module mmr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [mmr_pkg::NUM_W-1:0]   i_num,
    input  logic [mmr_pkg::RANGE_W-1:0] i_den,
    output logic                        o_done,
    output logic [mmr_pkg::SCALE_W-1:0] o_quo
);

    localparam int NUM_W = mmr_pkg::NUM_W;
    localparam int DEN_W = mmr_pkg::RANGE_W;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } t_dstate;

    t_dstate            r_state;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_quo;   // numerator shifts out, quotient shifts in

    logic [DEN_W:0]     rem_sh;
    logic               ge;
    logic [DEN_W-1:0]   n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        n_rem  = ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_go) begin
                        if (i_den == '0) begin
                            r_quo  <= NUM_W'(mmr_pkg::SCALE_ONE);
                            r_done <= 1'b1;
                        end else begin
                            r_quo   <= i_num;
                            r_den   <= i_den;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[NUM_W-2:0], ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(NUM_W - 1)) begin
                        r_state <= D_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = mmr_pkg::SCALE_W'(r_quo);

    `MMR_ASSERT_IMP(a_done_follows_work, i_clk, i_rst_n, r_done, $past(i_go) || $past(r_state == D_RUN))

endmodule

@@ hdl/mmr_scale.sv @@
`include "min_max_rescale_defines.svh"

// Four-stage rescale: offset, split multiply, combine, add base and clamp.
module mmr_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [mmr_pkg::DATA_W-1:0]   i_rdata,
    input  mmr_pkg::t_tag                i_tag,
    input  mmr_pkg::t_scale_cfg          i_cfg,
    output logic [mmr_pkg::DATA_W-1:0]   o_value,
    output mmr_pkg::t_tag                o_tag
);

    localparam int OFF_W   = mmr_pkg::OFF_W;
    localparam int PROD_W  = mmr_pkg::PROD_W;
    localparam int FULL_W  = mmr_pkg::FULL_W;
    localparam int STR_W   = mmr_pkg::STR_W;
    localparam int CAP_BIT = mmr_pkg::CAP_BIT;
    localparam int SUM_W   = mmr_pkg::SUM_W;
    localparam int MIN_W   = mmr_pkg::MIN_W;
    localparam int SPLIT   = mmr_pkg::SCALE_SPLIT;
    localparam int FRAC_W  = mmr_pkg::FRAC_W;

    mmr_pkg::t_tag r_tag [4];

    logic [OFF_W-1:0]           r_off;
    logic [OFF_W-1:0]           r_off_b;
    logic [PROD_W-1:0]          r_pl;
    logic [PROD_W-1:0]          r_ph;
    logic [STR_W-1:0]           r_p;
    logic [mmr_pkg::DATA_W-1:0] r_value;

    logic signed [MIN_W:0] diff;
    logic [FULL_W-1:0]     psum;
    logic                  p_big;
    logic signed [SUM_W-1:0] total;

    always_comb begin
        diff  = $signed({{2{i_rdata[mmr_pkg::DATA_W-1]}}, i_rdata})
              - $signed({i_cfg.minimum[MIN_W-1], i_cfg.minimum});
        psum  = (FULL_W'(r_ph) << SPLIT) + FULL_W'(r_pl);
        p_big = |psum[FULL_W-1:CAP_BIT];
        total = $signed({{(SUM_W - MIN_W){i_cfg.base[MIN_W-1]}}, i_cfg.base})
              + $signed({{(SUM_W - STR_W){1'b0}}, r_p});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_tag[i] <= '0;
            end
        end else begin
            r_tag[0] <= i_tag;
            for (int i = 1; i < 4; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // offset is never negative, fits 33 bits
        r_off   <= diff[OFF_W-1:0];
        r_pl    <= r_off * i_cfg.scale[SPLIT-1:0];
        r_ph    <= r_off * i_cfg.scale[mmr_pkg::SCALE_W-1:SPLIT];
        r_off_b <= r_off;
        // products at or above 2^62 are capped there before the shift
        if (!i_cfg.stretch) begin
            r_p <= STR_W'(r_off_b);
        end else if (p_big) begin
            r_p <= STR_W'(1) << (CAP_BIT - FRAC_W);
        end else begin
            r_p <= STR_W'(psum[CAP_BIT-1:FRAC_W]);
        end
        r_value <= mmr_pkg::sat_value(total);
    end

    assign o_value = r_value;
    assign o_tag   = r_tag[3];

    `MMR_ASSERT_IMP(a_fixed_latency, i_clk, i_rst_n, r_tag[3].vld, $past(i_tag.vld, 4))

endmodule

@@ hdl/min_max_rescale.sv @@
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+------------------------------
// input     | in        | start, busy               | i_item (t_in_item)
// result    | out       | o_valid, one cycle each   | o_item (t_out_item)
// config    | in        | i_cfg_we, i_cfg_idx       | i_cfg_data (32 bit)
//
// Loading takes one item per cycle while busy is low; each item is written
// to the value store and folded into the running min/max.
// After the item with block_end (or the one that fills the store) the block
// is busy for the range step and the restoring divider (one quotient bit a
// cycle, 47 bits; a scale of 1.0 without dividing when the found range is
// zero), then n store reads and the rescale pipeline, results coming one
// per cycle.
// Reset is synchronous, active low; the store itself is not cleared.
// Results cannot be stalled: each is on o_item for exactly one cycle.
module min_max_rescale #(
    parameter int BLOCK_DEPTH = mmr_pkg::BLOCK_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  mmr_pkg::t_in_item              i_item,
    output logic                           o_valid,
    output mmr_pkg::t_out_item             o_item,
    input  logic                           i_cfg_we,
    input  logic [mmr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mmr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

`include "min_max_rescale_defines.svh"

    localparam int CNT_W   = $clog2(BLOCK_DEPTH + 1);
    localparam int AW      = $clog2(BLOCK_DEPTH);
    localparam int DATA_W  = mmr_pkg::DATA_W;
    localparam int MIN_W   = mmr_pkg::MIN_W;
    localparam int RANGE_W = mmr_pkg::RANGE_W;
    localparam int SUM_W   = mmr_pkg::SUM_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RANGE,
        S_DIV,
        S_EMIT,
        S_DRAIN
    } t_state;

    t_state                          r_state;
    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                r_rd_idx;
    logic signed [MIN_W-1:0]         r_min;
    logic signed [MIN_W-1:0]         r_max;
    logic [RANGE_W-1:0]              r_range;
    logic [DATA_W-1:0]               r_frange;
    logic [DATA_W-1:0]               r_fmin;
    logic [mmr_pkg::SCALE_W-1:0]     r_scale;
    logic                            r_div_go;
    mmr_pkg::t_tag                   r_iss;

    // configuration registers
    logic signed [DATA_W-1:0]        r_tmin;
    logic [mmr_pkg::TRANGE_W-1:0]    r_trange;
    logic                            r_move;
    logic                            r_stretch;
    logic                            r_span;

    logic                            accept;
    logic                            blk_end;
    logic                            iss_last;
    logic signed [MIN_W-1:0]         v33;
    logic signed [MIN_W-1:0]         e33;
    logic signed [MIN_W-1:0]         lo;
    logic signed [MIN_W-1:0]         hi;
    logic signed [MIN_W-1:0]         n_min;
    logic signed [MIN_W-1:0]         n_max;

    logic [DATA_W-1:0]               rdata;
    logic                            div_done;
    logic [mmr_pkg::SCALE_W-1:0]     div_quo;
    mmr_pkg::t_scale_cfg             scfg;
    logic [DATA_W-1:0]               out_value;
    mmr_pkg::t_tag                   out_tag;

    assign busy   = (r_state != S_LOAD);
    assign accept = start && (r_state == S_LOAD);

    always_comb begin
        v33 = {i_item.sample_value[DATA_W-1], i_item.sample_value};
        e33 = v33 + {i_item.span_length[DATA_W-1], i_item.span_length};
        // start plus a negative duration lies below the start
        if (r_span && i_item.span_length[DATA_W-1]) begin
            lo = e33;
            hi = v33;
        end else if (r_span) begin
            lo = v33;
            hi = e33;
        end else begin
            lo = v33;
            hi = v33;
        end
        n_min    = (lo < r_min) ? lo : r_min;
        n_max    = (hi > r_max) ? hi : r_max;
        blk_end  = i_item.block_end || (r_count == CNT_W'(BLOCK_DEPTH - 1));
        iss_last = (r_rd_idx == r_count - CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_min     <= mmr_pkg::MIN_RESET;
            r_max     <= mmr_pkg::MAX_RESET;
            r_scale   <= mmr_pkg::SCALE_ONE;
            r_div_go  <= 1'b0;
            r_iss     <= '0;
            r_tmin    <= '0;
            r_trange  <= mmr_pkg::TRANGE_RESET;
            r_move    <= 1'b1;
            r_stretch <= 1'b1;
            r_span    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mmr_pkg::REG_TARGET_MIN:   r_tmin    <= i_cfg_data;
                    mmr_pkg::REG_TARGET_RANGE: r_trange  <= i_cfg_data[mmr_pkg::TRANGE_W-1:0];
                    mmr_pkg::REG_MOVE_MIN:     r_move    <= i_cfg_data[0];
                    mmr_pkg::REG_STRETCH:      r_stretch <= i_cfg_data[0];
                    mmr_pkg::REG_TIME_SPAN:    r_span    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            r_div_go <= 1'b0;
            r_iss    <= '0;

            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        r_count <= r_count + CNT_W'(1);
                        r_min   <= n_min;
                        r_max   <= n_max;
                        if (blk_end) begin
                            r_state <= S_RANGE;
                        end
                    end
                end
                S_RANGE: begin
                    r_range  <= RANGE_W'({r_max[MIN_W-1], r_max} - {r_min[MIN_W-1], r_min});
                    r_fmin   <= mmr_pkg::sat_value(
                                    $signed({{(SUM_W - MIN_W){r_min[MIN_W-1]}}, r_min}));
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    r_frange <= (|r_range[RANGE_W-1:DATA_W]) ? '1 : r_range[DATA_W-1:0];
                    if (div_done) begin
                        r_scale  <= div_quo;
                        r_rd_idx <= '0;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_iss.vld  <= 1'b1;
                    r_iss.last <= iss_last;
                    r_rd_idx   <= r_rd_idx + CNT_W'(1);
                    if (iss_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // last result leaves this cycle: block done
                    if (out_tag.vld && out_tag.last) begin
                        r_count <= '0;
                        r_min   <= mmr_pkg::MIN_RESET;
                        r_max   <= mmr_pkg::MAX_RESET;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    mmr_store #(
        .DEPTH (BLOCK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_item.sample_value),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    mmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   ({r_trange, {mmr_pkg::FRAC_W{1'b0}}}),
        .i_den   (r_range),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        scfg.minimum = r_min;
        scfg.scale   = r_scale;
        scfg.base    = r_move ? {r_tmin[DATA_W-1], r_tmin} : r_min;
        scfg.stretch = r_stretch;
    end

    mmr_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rdata (rdata),
        .i_tag   (r_iss),
        .i_cfg   (scfg),
        .o_value (out_value),
        .o_tag   (out_tag)
    );

    assign o_valid             = out_tag.vld;
    assign o_item.scaled_value = out_value;
    assign o_item.found_minimum = r_fmin;
    assign o_item.found_range  = r_frange;
    assign o_item.run_end      = out_tag.last;

    `MMR_ASSERT_IMP(a_result_only_emitting, i_clk, i_rst_n, o_valid, (r_state == S_EMIT) || (r_state == S_DRAIN))
    `MMR_ASSERT_IMP(a_store_not_overrun, i_clk, i_rst_n, accept, r_count < CNT_W'(BLOCK_DEPTH))
    `MMR_ASSERT_IMP(a_extremes_ordered, i_clk, i_rst_n, r_state == S_RANGE, r_min <= r_max)

endmodule
